@@ sv/bhha_pkg.sv @@
package bhha_pkg;

    localparam int HeapCellsDef   = 65536;
    localparam int HandleSlotsDef = 4096;

    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_FREE   = 3'd1;
    localparam logic [2:0] OP_LOAD   = 3'd2;
    localparam logic [2:0] OP_STORE  = 3'd3;
    localparam logic [2:0] OP_LENGTH = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_HEAP_FULL   = 3'd1;
    localparam logic [2:0] ST_NO_HANDLE   = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd3;
    localparam logic [2:0] ST_INVALID     = 3'd4;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;
    localparam logic [2:0] ST_OOB         = 3'd6;

endpackage

@@ sv/bhha_ram.sv @@
module bhha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bump_heap_handle_allocator.sv @@
// Bump heap allocator with a handle table. One operation is taken at a time;
// o_stall stays high from acceptance until the sequencer returns to idle.
// Operations pass through a shared adder/comparator and, as far as they go,
// the registered-read RAMs in turn; a load reads the handle table, then the
// heap. An operation may be rejected at the first check (zero size, heap
// full, null or unissued handle, unused code), after the handle table read,
// or, for an allocate with no handle left, at the fresh-handle check.
// The sequencer is back in idle in the same cycle as the result is
// registered, and a stalled output register holds the sequencer in its last
// state. A result may wait in the output register while the next beat is
// being accepted. After reset the heap is cleared one cell per cycle, and no
// beat is accepted until that pass ends.
module bump_heap_handle_allocator
    import bhha_pkg::*;
#(
    parameter int HEAP_CELLS   = HeapCellsDef,
    parameter int HANDLE_SLOTS = HandleSlotsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic [16:0]        i_block_cells,
    input  logic [11:0]        i_handle_id,
    input  logic [15:0]        i_cell_index,
    input  logic signed [63:0] i_store_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [11:0]        o_new_handle,
    output logic signed [63:0] o_read_data,
    output logic [2:0]         o_status
);

    localparam int HA_W  = $clog2(HEAP_CELLS);
    localparam int BP_W  = $clog2(HEAP_CELLS + 1);
    localparam int ID_W  = $clog2(HANDLE_SLOTS);
    localparam int CNT_W = $clog2(HANDLE_SLOTS + 1);
    localparam int MX_W  = (BP_W > CNT_W) ? BP_W : CNT_W;
    localparam int UW    = ((MX_W > 17) ? MX_W : 17) + 1;
    localparam int HT_W  = 1 + HA_W + BP_W;

    typedef struct packed {
        logic            valid;
        logic [HA_W-1:0] offset;
        logic [BP_W-1:0] size;
    } t_hent;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_FRESH = 10'b0000001000,
        S_POP   = 10'b0000010000,
        S_AWR   = 10'b0000100000,
        S_HT    = 10'b0001000000,
        S_ADDR  = 10'b0010000000,
        S_HRD   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [HA_W-1:0]  r_clr, n_clr;
    logic [BP_W-1:0]  r_bump, n_bump;
    logic [BP_W-1:0]  r_bump_nx, n_bump_nx;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [CNT_W-1:0] r_free_cnt, n_free_cnt;
    logic [2:0]       r_op, n_op;
    logic [16:0]      r_size, n_size;
    logic [11:0]      r_id, n_id;
    logic [15:0]      r_idx, n_idx;
    logic [63:0]      r_data, n_data;
    logic [ID_W-1:0]  r_nid, n_nid;
    logic [HA_W-1:0]  r_off, n_off;
    logic [11:0]      r_res_nh, n_res_nh;
    logic [63:0]      r_res_rd, n_res_rd;
    logic [2:0]       r_res_st, n_res_st;

    logic             r_o_valid;
    logic [11:0]      r_o_nh;
    logic [63:0]      r_o_rd;
    logic [2:0]       r_o_st;
    logic             out_free;

    logic [UW-1:0]    u_a, u_b, u_lim, u_sum;
    logic             u_gt;

    logic             heap_we;
    logic [HA_W-1:0]  heap_waddr;
    logic [63:0]      heap_wdata;
    logic [63:0]      heap_rdata;

    logic             ht_we;
    logic [ID_W-1:0]  ht_waddr;
    t_hent            ht_wdata;
    logic [ID_W-1:0]  ht_raddr;
    logic [HT_W-1:0]  ht_rbits;
    t_hent            ht_rdata;

    logic             stk_we;
    logic [ID_W-1:0]  stk_waddr;
    logic [ID_W-1:0]  stk_wdata;
    logic [ID_W-1:0]  stk_raddr;
    logic [ID_W-1:0]  stk_rdata;

    assign ht_rdata = t_hent'(ht_rbits);
    assign out_free = !r_o_valid || !i_stall;

    // shared adder / comparator
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_lim = '0;
        unique case (r_state)
            S_CHK: begin
                if (r_op == OP_ALLOC) begin
                    u_a   = UW'(r_bump);
                    u_b   = UW'(r_size);
                    u_lim = UW'(HEAP_CELLS);
                end else begin
                    u_a   = UW'(r_id);
                    u_b   = UW'(1);
                    u_lim = UW'(r_fresh);
                end
            end
            S_FRESH: begin
                u_a   = UW'(r_fresh);
                u_b   = UW'(1);
                u_lim = UW'(HANDLE_SLOTS);
            end
            S_HT: begin
                u_a   = UW'(r_idx);
                u_b   = UW'(1);
                u_lim = UW'(ht_rdata.size);
            end
            S_ADDR: begin
                u_a   = UW'(r_off);
                u_b   = UW'(r_idx);
                u_lim = UW'(HEAP_CELLS - 1);
            end
            default: begin
                u_a   = '0;
            end
        endcase
        u_sum = u_a + u_b;
        u_gt  = u_sum > u_lim;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_bump     = r_bump;
        n_bump_nx  = r_bump_nx;
        n_fresh    = r_fresh;
        n_free_cnt = r_free_cnt;
        n_op       = r_op;
        n_size     = r_size;
        n_id       = r_id;
        n_idx      = r_idx;
        n_data     = r_data;
        n_nid      = r_nid;
        n_off      = r_off;
        n_res_nh   = r_res_nh;
        n_res_rd   = r_res_rd;
        n_res_st   = r_res_st;

        heap_we    = 1'b0;
        heap_waddr = u_sum[HA_W-1:0];
        heap_wdata = r_data;
        ht_we      = 1'b0;
        ht_waddr   = ID_W'(r_id);
        ht_wdata   = ht_rdata;
        ht_raddr   = ID_W'(r_id);
        stk_we     = 1'b0;
        stk_waddr  = r_free_cnt[ID_W-1:0];
        stk_wdata  = ID_W'(r_id);
        stk_raddr  = ID_W'(r_free_cnt - CNT_W'(1));

        unique case (r_state)
            S_CLEAR: begin
                heap_we    = 1'b1;
                heap_waddr = r_clr;
                heap_wdata = '0;
                n_clr      = r_clr + HA_W'(1);
                if (r_clr == HA_W'(HEAP_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_operation;
                    n_size   = i_block_cells;
                    n_id     = i_handle_id;
                    n_idx    = i_cell_index;
                    n_data   = i_store_data;
                    n_res_nh = '0;
                    n_res_rd = '0;
                    n_res_st = ST_OK;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_DONE;
                if (r_op == OP_ALLOC) begin
                    n_bump_nx = BP_W'(u_sum);
                    if (r_size == '0) begin
                        n_res_st = ST_BAD_SIZE;
                    end else if (u_gt) begin
                        n_res_st = ST_HEAP_FULL;
                    end else if (r_free_cnt != '0) begin
                        n_free_cnt = r_free_cnt - CNT_W'(1);
                        n_state    = S_POP;
                    end else begin
                        n_state = S_FRESH;
                    end
                end else if (r_op == OP_FREE || r_op == OP_LOAD ||
                             r_op == OP_STORE || r_op == OP_LENGTH) begin
                    if (r_id == '0 || u_gt) begin
                        n_res_st = ST_INVALID;
                    end else begin
                        n_state = S_HT;
                    end
                end
            end
            S_FRESH: begin
                if (u_gt) begin
                    n_res_st = ST_NO_HANDLE;
                    n_state  = S_DONE;
                end else begin
                    n_nid   = ID_W'(r_fresh);
                    n_fresh = CNT_W'(u_sum);
                    n_state = S_AWR;
                end
            end
            S_POP: begin
                n_nid   = stk_rdata;
                n_state = S_AWR;
            end
            S_AWR: begin
                ht_we           = 1'b1;
                ht_waddr        = r_nid;
                ht_wdata.valid  = 1'b1;
                ht_wdata.offset = HA_W'(r_bump);
                ht_wdata.size   = BP_W'(r_size);
                n_bump          = r_bump_nx;
                n_res_nh        = 12'(r_nid);
                n_state         = S_DONE;
            end
            S_HT: begin
                n_state = S_DONE;
                if (r_op == OP_FREE) begin
                    if (!ht_rdata.valid) begin
                        n_res_st = ST_DOUBLE_FREE;
                    end else begin
                        ht_we          = 1'b1;
                        ht_wdata.valid = 1'b0;
                        if (r_free_cnt < CNT_W'(HANDLE_SLOTS)) begin
                            stk_we     = 1'b1;
                            n_free_cnt = r_free_cnt + CNT_W'(1);
                        end
                    end
                end else if (!ht_rdata.valid) begin
                    n_res_st = ST_INVALID;
                end else if (r_op == OP_LENGTH) begin
                    n_res_rd = 64'(ht_rdata.size);
                end else if (u_gt) begin
                    n_res_st = ST_OOB;
                end else begin
                    n_off   = ht_rdata.offset;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (u_gt) begin
                    n_res_st = ST_OOB;
                    n_state  = S_DONE;
                end else if (r_op == OP_STORE) begin
                    heap_we = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                n_res_rd = heap_rdata;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_bump     <= '0;
            r_fresh    <= CNT_W'(1);
            r_free_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_bump     <= n_bump;
            r_fresh    <= n_fresh;
            r_free_cnt <= n_free_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bump_nx <= n_bump_nx;
        r_op      <= n_op;
        r_size    <= n_size;
        r_id      <= n_id;
        r_idx     <= n_idx;
        r_data    <= n_data;
        r_nid     <= n_nid;
        r_off     <= n_off;
        r_res_nh  <= n_res_nh;
        r_res_rd  <= n_res_rd;
        r_res_st  <= n_res_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_nh <= r_res_nh;
            r_o_rd <= r_res_rd;
            r_o_st <= r_res_st;
        end
    end

    bhha_ram #(
        .WIDTH (64),
        .DEPTH (HEAP_CELLS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (u_sum[HA_W-1:0]),
        .o_rdata (heap_rdata)
    );

    bhha_ram #(
        .WIDTH (HT_W),
        .DEPTH (HANDLE_SLOTS)
    ) u_htab (
        .i_clk   (i_clk),
        .i_we    (ht_we),
        .i_waddr (ht_waddr),
        .i_wdata (HT_W'(ht_wdata)),
        .i_raddr (ht_raddr),
        .o_rdata (ht_rbits)
    );

    bhha_ram #(
        .WIDTH (ID_W),
        .DEPTH (HANDLE_SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_new_handle = r_o_nh;
    assign o_read_data  = r_o_rd;
    assign o_status     = r_o_st;

endmodule

@@ verif/bump_heap_handle_allocator_test.sv @@
`timescale 1ns / 1ps

module bump_heap_handle_allocator_test;
    import bhha_pkg::*;

    localparam logic [2:0]  OP_SPARE_FIRST  = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST   = 3'd7;
    localparam logic [63:0] DATA_MIN        = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DATA_MAX        = 64'h7fff_ffff_ffff_ffff;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          SETTLE_CYCLES   = 20;

    typedef struct packed {
        logic [11:0] new_handle;
        logic [63:0] read_data;
        logic [2:0]  status;
    } t_heap_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_operation = '0;
    logic [16:0]        i_block_cells = '0;
    logic [11:0]        i_handle_id = '0;
    logic [15:0]        i_cell_index = '0;
    logic signed [63:0] i_store_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [11:0]        o_new_handle;
    logic signed [63:0] o_read_data;
    logic [2:0]         o_status;

    // allocator state mirrored by the predictor
    logic [16:0] heap_top;
    logic [12:0] next_fresh_id;
    logic [15:0] blk_offset [HandleSlotsDef];
    logic [16:0] blk_size [HandleSlotsDef];
    bit          live_flag [HandleSlotsDef];
    logic [11:0] freed_ids [HandleSlotsDef];
    logic [12:0] freed_count;
    logic [63:0] heap_mem [HeapCellsDef];

    t_heap_reply heap_replies [$];
    t_heap_reply last_reply;
    int          granted_ids [$];
    int          mismatch_count = 0;
    int          sender_calm = 0;
    int          receiver_calm = 0;
    int          stall_left = 0;
    int          hold_request = 0;

    bump_heap_handle_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_block_cells (i_block_cells),
        .i_handle_id   (i_handle_id),
        .i_cell_index  (i_cell_index),
        .i_store_data  (i_store_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_new_handle  (o_new_handle),
        .o_read_data   (o_read_data),
        .o_status      (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic bit is_live(logic [11:0] id);
        return id != 0 && id < next_fresh_id && live_flag[id];
    endfunction

    function automatic logic [11:0] pick_live_id();
        if (granted_ids.size() == 0) return '0;
        return 12'(granted_ids[$urandom_range(0, granted_ids.size() - 1)]);
    endfunction

    function automatic void clear_heap_state();
        heap_top = '0;
        next_fresh_id = 13'd1;
        freed_count = '0;
        for (int k = 0; k < HandleSlotsDef; k++) begin
            blk_offset[k] = '0;
            blk_size[k] = '0;
            live_flag[k] = 1'b0;
            freed_ids[k] = '0;
        end
        for (int k = 0; k < HeapCellsDef; k++) heap_mem[k] = '0;
    endfunction

    function automatic t_heap_reply apply_heap_op(logic [2:0] op, logic [16:0] cells,
                                                  logic [11:0] id, logic [15:0] idx,
                                                  logic [63:0] data);
        t_heap_reply r;
        logic [12:0] nid;
        logic [16:0] addr;
        r = '0;
        case (op) inside
            OP_ALLOC: begin
                if (cells == 0) begin
                    r.status = ST_BAD_SIZE;
                end else if (int'(heap_top) + int'(cells) > HeapCellsDef) begin
                    r.status = ST_HEAP_FULL;
                end else begin
                    nid = '0;
                    if (freed_count != 0) begin
                        freed_count--;
                        nid = {1'b0, freed_ids[freed_count]};
                    end else if (next_fresh_id < HandleSlotsDef) begin
                        nid = next_fresh_id;
                        next_fresh_id++;
                    end
                    if (nid == 0) begin
                        r.status = ST_NO_HANDLE;
                    end else begin
                        blk_offset[nid] = heap_top[15:0];
                        blk_size[nid] = cells;
                        live_flag[nid] = 1'b1;
                        heap_top += cells;
                        r.new_handle = nid[11:0];
                    end
                end
            end
            OP_FREE: begin
                if (id == 0 || id >= next_fresh_id) begin
                    r.status = ST_INVALID;
                end else if (!live_flag[id]) begin
                    r.status = ST_DOUBLE_FREE;
                end else begin
                    live_flag[id] = 1'b0;
                    freed_ids[freed_count] = id;
                    freed_count++;
                end
            end
            OP_LOAD, OP_STORE: begin
                if (!is_live(id)) begin
                    r.status = ST_INVALID;
                end else if (idx >= blk_size[id]) begin
                    r.status = ST_OOB;
                end else begin
                    addr = blk_offset[id] + idx;
                    if (addr >= HeapCellsDef) r.status = ST_OOB;
                    else if (op == OP_LOAD) r.read_data = heap_mem[addr];
                    else heap_mem[addr] = data;
                end
            end
            OP_LENGTH: begin
                if (!is_live(id)) r.status = ST_INVALID;
                else r.read_data = 64'(blk_size[id]);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input logic [2:0] op, input logic [16:0] cells,
                           input logic [11:0] id, input logic [15:0] idx,
                           input logic [63:0] data);
        int gap;
        int k;
        gap = 0;
        if (sender_calm > 0) sender_calm--;
        else if ($urandom_range(0, 149) == 0) sender_calm = $urandom_range(20, 60);
        else gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_block_cells <= cells;
        i_handle_id <= id;
        i_cell_index <= idx;
        i_store_data <= data;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        last_reply = apply_heap_op(op, cells, id, idx, data);
        heap_replies = {heap_replies, last_reply};
        if (op == OP_ALLOC && last_reply.status == ST_OK)
            granted_ids = {granted_ids, int'(last_reply.new_handle)};
        if (op == OP_FREE && last_reply.status == ST_OK) begin
            for (k = 0; k < granted_ids.size(); k++) begin
                if (granted_ids[k] == id) begin
                    granted_ids.delete(k);
                    break;
                end
            end
        end
        @(negedge i_clk);
    endtask

    task automatic idle_until_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (heap_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed_cases();
        logic [11:0] h_small;
        logic [11:0] h_wide;
        int k;
        send_op(OP_ALLOC, 17'd0, 12'd0, 16'd0, 64'd0);
        send_op(OP_ALLOC, 17'd1, 12'd0, 16'd0, 64'd0);
        h_small = last_reply.new_handle;
        send_op(OP_ALLOC, 17'd16, 12'd0, 16'd0, 64'd0);
        h_wide = last_reply.new_handle;
        send_op(OP_LENGTH, 17'd0, h_small, 16'd0, 64'd0);
        send_op(OP_STORE, 17'd0, h_small, 16'd0, DATA_MIN);
        send_op(OP_LOAD, 17'd0, h_small, 16'd0, 64'd0);
        send_op(OP_STORE, 17'd0, h_wide, 16'd15, DATA_MAX);
        send_op(OP_LOAD, 17'd0, h_wide, 16'd15, 64'd0);
        send_op(OP_LOAD, 17'd0, h_wide, 16'd16, 64'd0);
        send_op(OP_STORE, 17'd0, h_wide, 16'hffff, '1);
        send_op(OP_LOAD, 17'd0, 12'd0, 16'd0, 64'd0);
        send_op(OP_FREE, 17'd0, 12'd0, 16'd0, 64'd0);
        send_op(OP_FREE, 17'd0, 12'hfff, 16'd0, 64'd0);
        send_op(OP_LENGTH, 17'd0, h_wide + 12'd1, 16'd0, 64'd0);
        send_op(OP_FREE, 17'd0, h_small, 16'd0, 64'd0);
        send_op(OP_FREE, 17'd0, h_small, 16'd0, 64'd0);
        send_op(OP_LOAD, 17'd0, h_small, 16'd0, 64'd0);
        send_op(OP_LENGTH, 17'd0, h_small, 16'd0, 64'd0);
        send_op(OP_ALLOC, 17'(HeapCellsDef), 12'd0, 16'd0, 64'd0);
        send_op(OP_ALLOC, 17'd3, 12'd0, 16'd0, 64'd0);
        send_op(OP_LOAD, 17'd0, last_reply.new_handle, 16'd2, 64'd0);
        send_op(OP_STORE, 17'd0, h_wide, 16'd0, '1);
        send_op(OP_LOAD, 17'd0, h_wide, 16'd0, 64'd0);
        for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            send_op(3'(k), 17'(HeapCellsDef), 12'hfff, 16'hffff, '1);
    endtask

    task automatic test_random_mix(input int count);
        int n;
        int r;
        int lo;
        logic [2:0]  op;
        logic [16:0] cells;
        logic [11:0] id;
        logic [15:0] idx;
        logic [63:0] data;
        for (n = 0; n < count; n++) begin
            data = {$urandom, $urandom};
            if ($urandom_range(0, 15) == 0) data = $urandom_range(0, 1) ? DATA_MIN : DATA_MAX;
            id = pick_live_id();
            idx = '0;
            cells = 17'($urandom_range(1, 16));
            r = $urandom_range(0, 99);
            if (r < 6) begin
                // junk beat; an allocate size here overflows the heap, or is zero while the heap is empty
                op = 3'($urandom_range(0, 7));
                id = 12'($urandom);
                idx = 16'($urandom);
                lo = HeapCellsDef - int'(heap_top) + 1;
                cells = (heap_top == 0) ? 17'd0 : 17'($urandom_range(lo, HeapCellsDef));
            end else if (r < 31 || granted_ids.size() == 0) begin
                op = OP_ALLOC;
                if ($urandom_range(0, 19) == 0) cells = 17'($urandom_range(17, 600));
                if ($urandom_range(0, 49) == 0) cells = '0;
            end else if (r < 50) begin
                op = OP_FREE;
                lo = $urandom_range(0, 9);
                if (lo == 0) id = 12'($urandom_range(0, next_fresh_id));
                else if (lo == 1 && freed_count != 0)
                    id = freed_ids[$urandom_range(0, freed_count - 1)];
            end else begin
                op = (r < 70) ? OP_LOAD : (r < 90) ? OP_STORE : OP_LENGTH;
                idx = 16'($urandom_range(0, blk_size[id] - 1));
                if ($urandom_range(0, 9) == 0)
                    idx = $urandom_range(0, 1) ? 16'(blk_size[id]) : 16'($urandom);
                if ($urandom_range(0, 9) == 0) id = 12'($urandom_range(0, next_fresh_id));
            end
            send_op(op, cells, id, idx, data);
        end
    endtask

    task automatic test_backpressure();
        idle_until_drained();
        hold_request = HOLD_OFF_CYCLES;
        sender_calm = 24;
        test_random_mix(24);
        idle_until_drained();
    endtask

    task automatic test_handle_exhaustion();
        int k;
        while (next_fresh_id < HandleSlotsDef || freed_count != 0) begin
            send_op(OP_ALLOC, 17'($urandom_range(1, 2)), 12'd0, 16'd0, 64'd0);
            if ($urandom_range(0, 7) == 0)
                send_op(OP_STORE, 17'd0, last_reply.new_handle, 16'd0, {$urandom, $urandom});
        end
        send_op(OP_ALLOC, 17'd1, 12'd0, 16'd0, 64'd0);
        for (k = 0; k < 6; k++) send_op(OP_FREE, 17'd0, pick_live_id(), 16'd0, 64'd0);
        send_op(OP_FREE, 17'd0, 12'hfff, 16'd0, 64'd0);
        send_op(OP_LENGTH, 17'd0, 12'hfff, 16'd0, 64'd0);
        repeat (9) send_op(OP_ALLOC, 17'd1, 12'd0, 16'd0, 64'd0);
    endtask

    task automatic test_heap_exhaustion();
        logic [11:0] id;
        logic [16:0] rest;
        send_op(OP_FREE, 17'd0, pick_live_id(), 16'd0, 64'd0);
        rest = 17'(HeapCellsDef - int'(heap_top));
        send_op(OP_ALLOC, rest, 12'd0, 16'd0, 64'd0);
        id = last_reply.new_handle;
        send_op(OP_ALLOC, 17'd1, 12'd0, 16'd0, 64'd0);
        send_op(OP_STORE, 17'd0, id, 16'(rest - 1), DATA_MAX);
        send_op(OP_LOAD, 17'd0, id, 16'(rest - 1), 64'd0);
        send_op(OP_LOAD, 17'd0, id, 16'(rest), 64'd0);
        send_op(OP_LENGTH, 17'd0, id, 16'd0, 64'd0);
        send_op(OP_FREE, 17'd0, id, 16'd0, 64'd0);
        send_op(OP_ALLOC, 17'd1, 12'd0, 16'd0, 64'd0);
    endtask

    // result side: random stalls, calm stretches, and the long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end else if (stall_left == 0) begin
                if (receiver_calm > 0) receiver_calm--;
                else if ($urandom_range(0, 149) == 0) receiver_calm = $urandom_range(20, 60);
                else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns  %s: expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : reply_check
        t_heap_reply want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (heap_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t ns  result beat with nothing pending: %h %h %h",
                         $time, o_new_handle, o_read_data, o_status);
            end else begin
                want = heap_replies.pop_front();
                check_field("new_handle", want.new_handle, o_new_handle);
                check_field("read_data", want.read_data, o_read_data);
                check_field("status", want.status, o_status);
            end
        end
    end

    initial begin
        clear_heap_state();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        idle_until_drained();
        test_random_mix(500);
        test_backpressure();
        test_random_mix(400);
        test_handle_exhaustion();
        idle_until_drained();
        test_heap_exhaustion();
        test_random_mix(250);
        idle_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
